/* rtl/sad_pkg.sv */
package sad_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_FLIPPED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_BANK   = 1'd1;

	// Decoded sprite entry, ready for expansion into draw commands
	typedef struct packed {
		logic [10:0]       code;
		logic [4:0]        color;
		logic              mirror_x;
		logic              mirror_y;
		logic signed [8:0] pos_x;
		logic signed [9:0] pos_y_first;
		logic signed [9:0] pos_y_second;
		logic              dbl;
	} entry_t;

endpackage

/* rtl/sad_sprite_if.sv */
interface sad_sprite_if;
	logic       valid;
	logic       ready;
	logic [7:0] y_byte;
	logic [7:0] attr_byte;
	logic [7:0] code_byte;
	logic [7:0] x_byte;

	modport source (output valid, output y_byte, output attr_byte, output code_byte,
		output x_byte, input ready);
	modport sink (input valid, input y_byte, input attr_byte, input code_byte,
		input x_byte, output ready);
endinterface

/* rtl/sad_cmd_if.sv */
interface sad_cmd_if;
	logic              valid;
	logic              ready;
	logic [10:0]       tile_code;
	logic [4:0]        tile_color;
	logic              mirror_x;
	logic              mirror_y;
	logic signed [8:0] pos_x;
	logic signed [9:0] pos_y;
	logic              last_of_sprite;

	modport source (output valid, output tile_code, output tile_color, output mirror_x,
		output mirror_y, output pos_x, output pos_y, output last_of_sprite, input ready);
	modport sink (input valid, input tile_code, input tile_color, input mirror_x,
		input mirror_y, input pos_x, input pos_y, input last_of_sprite, output ready);
endinterface

/* rtl/sprite_attribute_decoder.sv */
// Sprite attribute decoder: one four-byte sprite entry in, one or two draw commands out.
// An entry is registered in stage 1, stage 2 and the output register before its first
// command is presented; stalls from out_ch.ready can come between them.
// Throughput: one entry per cycle for normal height while out_ch.ready is high; a double
// height entry is held while the output stage issues one command a cycle, unless stalled.
// Reset (arst_n low, asynchronous) clears all stage valid bits, the command phase
// and both configuration registers.
module sprite_attribute_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [sad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sad_pkg::CFG_DATA_W-1:0] cfg_wdata,
	sad_sprite_if.sink                     in_ch,
	sad_cmd_if.source                      out_ch
);

	// Configuration registers
	logic       flip_q;
	logic [1:0] bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q <= 1'b0;
			bank_q <= 2'd0;
		end else if (cfg_wen) begin
			case (cfg_index)
				sad_pkg::REG_SCREEN_FLIPPED: flip_q <= cfg_wdata[0];
				sad_pkg::REG_PALETTE_BANK:   bank_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// Pipeline handshake: each stage advances when the next one is empty or draining
	logic valid_s1, valid_s2;
	logic ld1, ld2, pop2;

	assign ld2         = valid_s1 && (!valid_s2 || pop2);
	assign in_ch.ready = !valid_s1 || ld2;
	assign ld1         = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (!valid_s2 || pop2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage 1: mirror x about 240 under screen flip and y about 240 when not flipped, capture with flip and bank
	logic signed [9:0] x_in, y_in, sx_in, sy_in;
	logic signed [9:0] sx_s1, sy_s1;
	logic [7:0]        attr_s1, code_s1;
	logic              flip_s1;
	logic [1:0]        bank_s1;

	always_comb begin
		x_in  = $signed({2'b00, in_ch.x_byte});
		y_in  = $signed({2'b00, in_ch.y_byte});
		sx_in = flip_q ? (10'sd240 - x_in) : x_in;
		sy_in = flip_q ? y_in : (10'sd240 - y_in);
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			sx_s1   <= sx_in;
			sy_s1   <= sy_in;
			attr_s1 <= in_ch.attr_byte;
			code_s1 <= in_ch.code_byte;
			flip_s1 <= flip_q;
			bank_s1 <= bank_q;
		end
	end

	// Stage 2 logic: wrap into the visible window
	logic signed [9:0] sx_wrap;
	logic signed [9:0] sy_wrap;
	logic signed [9:0] sy_dbl;
	logic              dbl;
	sad_pkg::entry_t   ent_d;

	always_comb begin
		dbl = attr_s1[7];

		if (sx_s1 < -10'sd8) begin
			sx_wrap = sx_s1 + 10'sd256;
		end else if (sx_s1 > 10'sd248) begin
			sx_wrap = sx_s1 - 10'sd256;
		end else begin
			sx_wrap = sx_s1;
		end

		if (sy_s1 < -10'sd8) begin
			sy_wrap = sy_s1 + 10'sd256;
		end else if (sy_s1 > 10'sd248) begin
			sy_wrap = sy_s1 - 10'sd256;
		end else begin
			sy_wrap = sy_s1;
		end

		// double height wraps on the lower tile's position instead
		if (flip_s1) begin
			sy_dbl = (sy_s1 > 10'sd240) ? (sy_s1 - 10'sd256) : sy_s1;
		end else begin
			sy_dbl = (sy_s1 < 10'sd0) ? (sy_s1 + 10'sd256) : sy_s1;
		end

		ent_d.code         = {attr_s1[2:0], code_s1[7:1], code_s1[0] & !dbl};
		ent_d.color        = {bank_s1, attr_s1[5:3]};
		ent_d.mirror_x     = !attr_s1[6] ^ flip_s1;
		ent_d.mirror_y     = flip_s1;
		ent_d.pos_x        = sx_wrap[8:0];
		ent_d.pos_y_second = dbl ? sy_dbl : sy_wrap;
		ent_d.pos_y_first  = flip_s1 ? (sy_dbl + 10'sd16) : (sy_dbl - 10'sd16);
		ent_d.dbl          = dbl;
	end

	// Stage 2 register: hold the decoded entry until its last command is issued
	sad_pkg::entry_t ent_s2;

	always_ff @(posedge clk) begin
		if (ld2) begin
			ent_s2 <= ent_d;
		end
	end

	// Stage 3: expand into commands behind the output register
	sad_expand u_expand (
		.clk       (clk),
		.arst_n    (arst_n),
		.ent_valid (valid_s2),
		.ent       (ent_s2),
		.ent_pop   (pop2),
		.out_ch    (out_ch)
	);

endmodule

/* rtl/sad_expand.sv */
module sad_expand (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ent_valid,
	input  sad_pkg::entry_t ent,
	output logic            ent_pop,
	sad_cmd_if.source       out_ch
);

	logic        valid_s3;
	logic        phase_q;
	logic        load;
	logic        is_last;
	logic [10:0] code_s3;
	logic [4:0]  color_s3;
	logic        mx_s3;
	logic        my_s3;
	logic signed [8:0] px_s3;
	logic signed [9:0] py_s3;
	logic        last_s3;

	assign load    = ent_valid && (!valid_s3 || out_ch.ready);
	assign is_last = !ent.dbl || phase_q;
	assign ent_pop = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_s3 <= 1'b1;
				phase_q  <= !is_last;
			end else if (out_ch.ready) begin
				valid_s3 <= 1'b0;
			end
		end
	end

	// Payload: second command of a double-height sprite takes the odd code
	always_ff @(posedge clk) begin
		if (load) begin
			code_s3  <= ent.code | {10'd0, phase_q};
			color_s3 <= ent.color;
			mx_s3    <= ent.mirror_x;
			my_s3    <= ent.mirror_y;
			px_s3    <= ent.pos_x;
			py_s3    <= (ent.dbl && !phase_q) ? ent.pos_y_first : ent.pos_y_second;
			last_s3  <= is_last;
		end
	end

	assign out_ch.valid          = valid_s3;
	assign out_ch.tile_code      = code_s3;
	assign out_ch.tile_color     = color_s3;
	assign out_ch.mirror_x       = mx_s3;
	assign out_ch.mirror_y       = my_s3;
	assign out_ch.pos_x          = px_s3;
	assign out_ch.pos_y          = py_s3;
	assign out_ch.last_of_sprite = last_s3;

endmodule

/* rtl/sad_checker.sv */
module sad_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [10:0]       tile_code,
	input logic [4:0]        tile_color,
	input logic              mirror_y,
	input logic signed [8:0] pos_x,
	input logic signed [9:0] pos_y,
	input logic              last_of_sprite
);

	// Hold a stalled command
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tile_code) && $stable(pos_y))
		else $error("stalled command changed");

	// Upper tile of a double-height sprite is followed at once by its odd partner
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_sprite |=>
		out_valid && last_of_sprite && tile_code == ($past(tile_code) | 11'd1) &&
		$past(tile_code[0]) == 1'b0)
		else $error("double-height pair broken");

	// Both halves share colour, vertical mirror and x position; their rows sit 16 apart
	a_pair_attr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_sprite |=>
		$stable(tile_color) && $stable(mirror_y) && $stable(pos_x) &&
		((pos_y - $past(pos_y)) == 10'sd16 || (pos_y - $past(pos_y)) == -10'sd16))
		else $error("double-height halves disagree");

	// No command while reset is held
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("command shown during reset");

endmodule

bind sprite_attribute_decoder sad_checker u_sad_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.tile_code      (out_ch.tile_code),
	.tile_color     (out_ch.tile_color),
	.mirror_y       (out_ch.mirror_y),
	.pos_x          (out_ch.pos_x),
	.pos_y          (out_ch.pos_y),
	.last_of_sprite (out_ch.last_of_sprite)
);
